@@ rtl/qmj_pkg.sv @@
// Shared constants, operation codes and control types of the minimum-jerk trajectory core.
package qmj_pkg;

    localparam int TIME_FRAC_BITS_DEF = 24;

    localparam int DUR_W   = 16;
    localparam int POS_W   = 19;
    localparam int DIST_W  = 20;
    localparam int MAG_W   = 19;
    localparam int PM_W    = 20;
    localparam int VEL_W   = 28;
    localparam int VQ_W    = 29;

    localparam logic [DUR_W-1:0]        DURATION_RESET = 16'd200;
    localparam logic signed [POS_W-1:0] POS_LIMIT      = 19'sd131584;

    localparam int APB_ADDR_W = 2;
    localparam logic [APB_ADDR_W-1:0] ADDR_DURATION = 2'd0;

    typedef logic [2:0] t_op;

    localparam t_op OP_S2   = 3'd0;
    localparam t_op OP_S3   = 3'd1;
    localparam t_op OP_H    = 3'd2;
    localparam t_op OP_SW   = 3'd3;
    localparam t_op OP_W2   = 3'd4;
    localparam t_op OP_PM   = 3'd5;
    localparam t_op OP_VX   = 3'd6;
    localparam t_op OP_LAST = OP_VX;

    typedef struct packed {
        logic load;
        logic div_s_start;
        logic s_capture;
        logic mul;
        logic store;
        t_op  op;
        logic div_v_start;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_sts;

    function automatic logic signed [POS_W-1:0] clamp_pos(input logic signed [POS_W-1:0] p);
        logic signed [POS_W-1:0] r;
        r = p;
        if (p > POS_LIMIT) begin
            r = POS_LIMIT;
        end else if (p < -POS_LIMIT) begin
            r = -POS_LIMIT;
        end
        return r;
    endfunction

endpackage

@@ rtl/quintic_min_jerk_trajectory_core.sv @@
// Top level of the single-axis minimum-jerk trajectory core with its APB register port.
// One request is processed at a time: the core is busy from an accepted request until its result
// is loaded, through the bit-serial divider (TIME_FRAC_BITS + 1 steps for the time fraction,
// 29 for the velocity) and seven multiplies.
// A finished result waits in the output register while the next request is accepted.
// Synchronous active-low reset clears the control, the move state and sets duration to 200.
module quintic_min_jerk_trajectory_core
    import qmj_pkg::*;
#(
    parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_action,
    input  logic signed [POS_W-1:0]  i_start_position,
    input  logic signed [POS_W-1:0]  i_target_position,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [POS_W-1:0]  o_goal_position,
    output logic signed [VEL_W-1:0]  o_goal_velocity,
    output logic                     o_finished,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [DUR_W-1:0] r_duration;
    t_dp_cmd          cmd;
    t_dp_sts          sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration <= DURATION_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_DURATION)) begin
            r_duration <= pwdata[DUR_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_DURATION) ? {{(32-DUR_W){1'b0}}, r_duration} : 32'd0;

    qmj_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    qmj_dp #(
        .TIME_FRAC_BITS (TIME_FRAC_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_duration        (r_duration),
        .i_action          (i_action),
        .i_start_position  (i_start_position),
        .i_target_position (i_target_position),
        .o_goal_position   (o_goal_position),
        .o_goal_velocity   (o_goal_velocity),
        .o_finished        (o_finished)
    );

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted but core did not go busy");

    a_finished_no_velocity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_finished) |-> (o_goal_velocity == 28'sd0))
        else $error("finished result carries a nonzero velocity");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result appeared without a computation in progress");

endmodule

@@ rtl/qmj_div.sv @@
// Radix-2 restoring divider that produces one quotient bit per cycle.
module qmj_div
    import qmj_pkg::*;
#(
    parameter int QW = 33
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DUR_W-1:0]         i_rem,
    input  logic [QW-1:0]            i_bits,
    input  logic [$clog2(QW+1)-1:0]  i_count,
    input  logic [DUR_W-1:0]         i_divisor,
    output logic [QW-1:0]            o_quot,
    output logic                     o_done
);

    localparam int CW = $clog2(QW+1);

    logic [DUR_W-1:0] r_rem;
    logic [QW-1:0]    r_bits;
    logic [QW-1:0]    r_quot;
    logic [CW-1:0]    r_cnt;
    logic             r_done;

    logic [DUR_W:0]   rem_sh;
    logic [DUR_W:0]   diff;
    logic             ge;

    always_comb begin
        rem_sh = {r_rem, r_bits[QW-1]};
        diff   = rem_sh - {1'b0, i_divisor};
        ge     = (rem_sh >= {1'b0, i_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1)) && !i_start;
            if (i_start) begin
                r_cnt <= i_count;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_rem;
            r_bits <= i_bits;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= ge ? diff[DUR_W-1:0] : rem_sh[DUR_W-1:0];
            r_bits <= r_bits << 1;
            r_quot <= {r_quot[QW-2:0], ge};
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

@@ rtl/qmj_dp.sv @@
// Datapath: move state, shared multiplier, shared divider and result registers.
module qmj_dp
    import qmj_pkg::*;
#(
    parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    input  logic [DUR_W-1:0]         i_duration,
    input  logic                     i_action,
    input  logic signed [POS_W-1:0]  i_start_position,
    input  logic signed [POS_W-1:0]  i_target_position,
    output logic signed [POS_W-1:0]  o_goal_position,
    output logic signed [VEL_W-1:0]  o_goal_velocity,
    output logic                     o_finished
);

    localparam int F   = TIME_FRAC_BITS;
    localparam int SW  = F + 1;
    localparam int MW  = F + 4;
    localparam int GW  = F + 5;
    localparam int PW  = 2 * MW;
    localparam int DW  = DUR_W + F;
    localparam int YFW = PW + 9;
    localparam int QW  = (SW > VQ_W) ? SW : VQ_W;
    localparam int CW  = $clog2(QW + 1);

    localparam logic [SW-1:0] ONE  = {1'b1, {F{1'b0}}};
    localparam logic [PW:0]   HALF = (PW+1)'(1) << (F - 1);

    logic [DUR_W-1:0]         r_tick;
    logic signed [POS_W-1:0]  r_origin;
    logic signed [DIST_W-1:0] r_dist;

    logic [SW-1:0] r_s;
    logic [SW-1:0] r_s2;
    logic [SW-1:0] r_s3;
    logic [SW-1:0] r_h;
    logic [SW-1:0] r_sw;
    logic [SW-1:0] r_w2;
    logic [PM_W-1:0] r_pm;
    logic [PW-1:0] r_prod;

    logic signed [POS_W-1:0] r_out_pos;
    logic signed [VEL_W-1:0] r_out_vel;
    logic                    r_out_fin;

    logic [DUR_W-1:0]        dur_eff;
    logic [DUR_W-1:0]        ticks_eff;
    logic signed [POS_W-1:0] ca;
    logic signed [POS_W-1:0] cb;
    logic                    neg;
    logic [DIST_W-1:0]       mag_full;
    logic [MAG_W-1:0]        mag;
    logic [DW-1:0]           d1;
    logic [GW-1:0]           g;
    logic [MW-1:0]           v;
    logic [SW-1:0]           omx;
    logic [MW-1:0]           op_a;
    logic [MW-1:0]           op_b;
    logic [PW-1:0]           prod;
    logic [PW:0]             rnd_full;
    logic [PW:0]             rnd;
    logic [YFW-1:0]          y_full;
    logic [VQ_W-1:0]         y;
    logic                    dv_start;
    logic [DUR_W-1:0]        dv_rem;
    logic [QW-1:0]           dv_bits;
    logic [CW-1:0]           dv_count;
    logic [QW-1:0]           dv_quot;
    logic                    dv_done;
    logic [VQ_W-1:0]         vm;
    logic [VQ_W-1:0]         vm_neg;
    logic signed [VEL_W-1:0] vel;
    logic [POS_W+1:0]        pos_full;
    logic [POS_W+1:0]        pm_ext;

    always_comb begin
        dur_eff   = (i_duration == '0) ? DUR_W'(1) : i_duration;
        ticks_eff = (r_tick < dur_eff) ? r_tick : dur_eff;
        ca        = clamp_pos(i_start_position);
        cb        = clamp_pos(i_target_position);
        neg       = r_dist[DIST_W-1];
        mag_full  = neg ? (DIST_W'(0) - DIST_W'(r_dist)) : DIST_W'(r_dist);
        mag       = mag_full[MAG_W-1:0];
        d1        = {ticks_eff, {F{1'b0}}} + DW'(dur_eff >> 1);
        g         = (GW'(ONE) << 3) + (GW'(ONE) << 1) + (GW'(r_s2) << 2) + (GW'(r_s2) << 1)
                  - ((GW'(r_s) << 4) - GW'(r_s));
        v         = (MW'(r_w2) << 5) - (MW'(r_w2) << 1);
        omx       = ONE - r_s;
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (i_cmd.op)
            OP_S2: begin
                op_a = MW'(r_s);
                op_b = MW'(r_s);
            end
            OP_S3: begin
                op_a = MW'(r_s2);
                op_b = MW'(r_s);
            end
            OP_H: begin
                op_a = MW'(r_s3);
                op_b = g[MW-1:0];
            end
            OP_SW: begin
                op_a = MW'(r_s);
                op_b = MW'(omx);
            end
            OP_W2: begin
                op_a = MW'(r_sw);
                op_b = MW'(r_sw);
            end
            OP_PM: begin
                op_a = MW'(mag);
                op_b = MW'(r_h);
            end
            OP_VX: begin
                op_a = MW'(mag);
                op_b = v;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod     = op_a * op_b;
    assign rnd_full = (PW+1)'(r_prod) + HALF;
    assign rnd      = rnd_full >> F;
    assign y_full   = (YFW'(r_prod) << 8) + (YFW'(dur_eff) << (F - 1));
    assign y        = VQ_W'(y_full >> F);

    always_comb begin
        dv_start = i_cmd.div_s_start | i_cmd.div_v_start;
        if (i_cmd.div_v_start) begin
            dv_rem   = '0;
            dv_bits  = QW'(y) << (QW - VQ_W);
            dv_count = CW'(VQ_W);
        end else begin
            dv_rem   = DUR_W'(d1 >> SW);
            dv_bits  = QW'(d1[SW-1:0]) << (QW - SW);
            dv_count = CW'(SW);
        end
    end

    qmj_div #(
        .QW (QW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (dv_start),
        .i_rem     (dv_rem),
        .i_bits    (dv_bits),
        .i_count   (dv_count),
        .i_divisor (dur_eff),
        .o_quot    (dv_quot),
        .o_done    (dv_done)
    );

    assign o_sts.div_done = dv_done;

    always_comb begin
        vm     = dv_quot[VQ_W-1:0];
        vm_neg = VQ_W'(0) - vm;
        if (neg) begin
            if (vm >= (VQ_W'(1) << (VEL_W - 1))) begin
                vel = {1'b1, {(VEL_W-1){1'b0}}};
            end else begin
                vel = vm_neg[VEL_W-1:0];
            end
        end else begin
            if (vm > VQ_W'({1'b0, {(VEL_W-1){1'b1}}})) begin
                vel = {1'b0, {(VEL_W-1){1'b1}}};
            end else begin
                vel = vm[VEL_W-1:0];
            end
        end
        pm_ext   = neg ? ((POS_W+2)'(0) - (POS_W+2)'(r_pm)) : (POS_W+2)'(r_pm);
        pos_full = {{2{r_origin[POS_W-1]}}, r_origin} + pm_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_origin <= '0;
            r_dist   <= '0;
        end else if (i_cmd.load) begin
            if (!i_action) begin
                r_origin <= ca;
                r_dist   <= {cb[POS_W-1], cb} - {ca[POS_W-1], ca};
                r_tick   <= '0;
            end else if (r_tick < dur_eff) begin
                r_tick <= r_tick + DUR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.s_capture) begin
            r_s <= dv_quot[SW-1:0];
        end
        if (i_cmd.mul) begin
            r_prod <= prod;
        end
        if (i_cmd.store) begin
            unique case (i_cmd.op)
                OP_S2:   r_s2 <= rnd[SW-1:0];
                OP_S3:   r_s3 <= rnd[SW-1:0];
                OP_H:    r_h  <= rnd[SW-1:0];
                OP_SW:   r_sw <= rnd[SW-1:0];
                OP_W2:   r_w2 <= rnd[SW-1:0];
                OP_PM:   r_pm <= rnd[PM_W-1:0];
                default: begin
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_pos <= pos_full[POS_W-1:0];
            r_out_vel <= vel;
            r_out_fin <= (r_tick >= dur_eff);
        end
    end

    assign o_goal_position = r_out_pos;
    assign o_goal_velocity = r_out_vel;
    assign o_finished      = r_out_fin;

endmodule

@@ rtl/qmj_ctrl.sv @@
// Controller state machine that sequences the divider and multiplier steps of one request.
module qmj_ctrl
    import qmj_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV_S  = 3'd1;
    localparam logic [2:0] ST_WAIT_S = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_STORE  = 3'd4;
    localparam logic [2:0] ST_DIV_V  = 3'd5;
    localparam logic [2:0] ST_WAIT_V = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_op        r_op;
    t_op        n_op;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.op    = r_op;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV_S;
                end
            end
            ST_DIV_S: begin
                o_cmd.div_s_start = 1'b1;
                n_state           = ST_WAIT_S;
            end
            ST_WAIT_S: begin
                if (i_sts.div_done) begin
                    o_cmd.s_capture = 1'b1;
                    n_op            = OP_S2;
                    n_state         = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_STORE;
            end
            ST_STORE: begin
                o_cmd.store = 1'b1;
                if (r_op == OP_LAST) begin
                    n_state = ST_DIV_V;
                end else begin
                    n_op    = r_op + 3'd1;
                    n_state = ST_MUL;
                end
            end
            ST_DIV_V: begin
                o_cmd.div_v_start = 1'b1;
                n_state           = ST_WAIT_V;
            end
            ST_WAIT_V: begin
                if (i_sts.div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_S2;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the minimum-jerk trajectory core with its own profile predictor.
module testbench;
    import qmj_pkg::*;

    localparam int     FRAC          = TIME_FRAC_BITS_DEF;
    localparam logic   ACT_START     = 1'b0;
    localparam logic   ACT_TICK      = 1'b1;
    localparam int     QUIET_LIMIT   = 5000;
    localparam int     SETTLE_CYCLES = 100;
    localparam int     MISMATCH_SHOW = 10;
    localparam int     POS_SPAN      = 131584;
    localparam longint VEL_TOP       = 134217727;
    localparam longint VEL_BOTTOM    = -134217728;

    typedef struct packed {
        logic                    action;
        logic signed [POS_W-1:0] start_pos;
        logic signed [POS_W-1:0] target_pos;
    } t_move_req;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic signed [VEL_W-1:0] velocity;
        logic                    finished;
    } t_point;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic                    i_action = ACT_START;
    logic signed [POS_W-1:0] i_start_position = '0;
    logic signed [POS_W-1:0] i_target_position = '0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic signed [POS_W-1:0] o_goal_position;
    logic signed [VEL_W-1:0] o_goal_velocity;
    logic                    o_finished;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr = ADDR_DURATION;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;

    t_move_req request_queue[$];
    t_point    expected_points[$];

    logic [DUR_W-1:0] axis_duration = DURATION_RESET;
    logic [DUR_W-1:0] axis_ticks = '0;
    longint           axis_origin = 0;
    longint           axis_distance = 0;

    int send_idle_pct = 12;
    int recv_idle_pct = 59;
    int requests_sent = 0;
    int points_checked = 0;
    int mismatch_count = 0;
    int settings_used = 0;
    int quiet_cycles = 0;

    quintic_min_jerk_trajectory_core i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [63:0] frac_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = a * b + (128'd1 << (FRAC - 1));
        return p[FRAC +: 64];
    endfunction

    function automatic longint clip_to_limit(input longint p);
        if (p > POS_SPAN) return POS_SPAN;
        if (p < -POS_SPAN) return -POS_SPAN;
        return p;
    endfunction

    // Advances the axis by one request and returns the profile point it answers.
    function automatic t_point step_axis(input t_move_req req);
        logic [63:0] n_dur, n, one, s, s2, s3, g, h, sw, v, mag, pm, den, vm;
        longint      a, b, pos_full, vel_full;
        logic        neg;
        t_point      pt;
        n_dur = (axis_duration == 0) ? 64'd1 : 64'(axis_duration);
        if (req.action == ACT_START) begin
            a = clip_to_limit(longint'(req.start_pos));
            b = clip_to_limit(longint'(req.target_pos));
            axis_origin = a;
            axis_distance = b - a;
            axis_ticks = '0;
        end else if (64'(axis_ticks) < n_dur) begin
            axis_ticks = axis_ticks + 1'b1;
        end
        n = (64'(axis_ticks) < n_dur) ? 64'(axis_ticks) : n_dur;
        one = 64'd1 << FRAC;
        s = ((n << FRAC) + n_dur / 2) / n_dur;
        s2 = frac_mul(s, s);
        s3 = frac_mul(s2, s);
        g = 10 * one + 6 * s2 - 15 * s;
        h = frac_mul(s3, g);
        sw = frac_mul(s, one - s);
        v = 30 * frac_mul(sw, sw);
        neg = axis_distance < 0;
        mag = neg ? 64'(-axis_distance) : 64'(axis_distance);
        pm = (mag * h + (one >> 1)) >> FRAC;
        den = n_dur << FRAC;
        vm = (((mag * v) << 8) + den / 2) / den;
        if (vm > (64'd1 << (VEL_W - 1))) begin
            vm = 64'd1 << (VEL_W - 1);
        end
        vel_full = neg ? -longint'(vm) : longint'(vm);
        if (vel_full > VEL_TOP) vel_full = VEL_TOP;
        if (vel_full < VEL_BOTTOM) vel_full = VEL_BOTTOM;
        pos_full = axis_origin + (neg ? -longint'(pm) : longint'(pm));
        pt.position = pos_full[POS_W-1:0];
        pt.velocity = vel_full[VEL_W-1:0];
        pt.finished = 64'(axis_ticks) >= n_dur;
        return pt;
    endfunction

    function automatic logic signed [POS_W-1:0] pick_position();
        int roll;
        roll = $urandom_range(19);
        if (roll == 0) return POS_W'($urandom());
        if (roll == 1) return POS_W'(POS_SPAN);
        if (roll == 2) return POS_W'(-POS_SPAN);
        return POS_W'(int'($urandom_range(2 * POS_SPAN)) - POS_SPAN);
    endfunction

    function automatic void queue_request(input logic action, input int start_pos,
                                          input int target_pos);
        t_move_req req;
        req.action = action;
        req.start_pos = POS_W'(start_pos);
        req.target_pos = POS_W'(target_pos);
        request_queue.push_back(req);
    endfunction

    // Mostly whole moves (a start and a run of ticks), with stray ticks and cut-off moves.
    task automatic queue_moves(input int count);
        int added, roll, ticks, cap;
        added = 0;
        cap = (int'(axis_duration) + 2 < 60) ? int'(axis_duration) + 2 : 60;
        while (added < count) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                ticks = $urandom_range(1, 3);
            end else begin
                queue_request(ACT_START, pick_position(), pick_position());
                added++;
                if (roll < 14) begin
                    ticks = 0;
                end else if ($urandom_range(1) == 1) begin
                    ticks = cap;
                end else begin
                    ticks = $urandom_range(0, cap);
                end
            end
            repeat (ticks) begin
                queue_request(ACT_TICK, pick_position(), pick_position());
                added++;
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (request_queue.size() != 0 || i_valid || expected_points.size() != 0);
    endtask

    task automatic write_duration(input logic [DUR_W-1:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_DURATION;
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        axis_duration = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== 32'(value)) begin
            mismatch_count++;
            if (mismatch_count <= MISMATCH_SHOW) begin
                $display("duration readback: expected %0d actual %0d", value, prdata);
            end
        end
        psel <= 1'b0;
        penable <= 1'b0;
        settings_used++;
    endtask

    always @(posedge i_clk) begin : drive_requests
        t_move_req accepted_req;
        t_move_req next_req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                accepted_req = {i_action, i_start_position, i_target_position};
                expected_points.push_back(step_axis(accepted_req));
                requests_sent++;
            end
            if (!i_valid || o_ready) begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = request_queue.pop_front();
                    i_action <= next_req.action;
                    i_start_position <= next_req.start_pos;
                    i_target_position <= next_req.target_pos;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_points
        t_point want;
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_points.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MISMATCH_SHOW) begin
                    $display("unexpected point: position %0d velocity %0d finished %0b",
                             o_goal_position, o_goal_velocity, o_finished);
                end
            end else begin
                want = expected_points.pop_front();
                points_checked++;
                if (o_goal_position !== want.position || o_goal_velocity !== want.velocity ||
                    o_finished !== want.finished) begin
                    mismatch_count++;
                    if (mismatch_count <= MISMATCH_SHOW) begin
                        $display({"point %0d: expected pos %0d vel %0d fin %0b,",
                                  " actual pos %0d vel %0d fin %0b"},
                                 points_checked, want.position, want.velocity, want.finished,
                                 o_goal_position, o_goal_velocity, o_finished);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no request or point moved for %0d cycles", QUIET_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : run_test
        int phase;
        int dur;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A tick from the reset state, full-range moves and saturated positions.
        queue_request(ACT_TICK, 0, 0);
        queue_request(ACT_START, -POS_SPAN, POS_SPAN);
        queue_request(ACT_TICK, 0, 0);
        queue_request(ACT_TICK, -1, -1);
        queue_request(ACT_START, -262144, 262143);
        queue_request(ACT_TICK, 262143, -262144);
        queue_request(ACT_START, 0, 0);
        queue_request(ACT_TICK, 0, 0);
        wait_drained();

        // A zero duration acts as a single tick, and finished moves hold their end point.
        write_duration(DUR_W'(0));
        queue_request(ACT_START, 100, -100);
        queue_request(ACT_TICK, 0, 0);
        queue_request(ACT_TICK, 0, 0);
        wait_drained();

        write_duration(DUR_W'(5));
        queue_request(ACT_START, POS_SPAN, -POS_SPAN);
        repeat (6) queue_request(ACT_TICK, 0, 0);
        wait_drained();

        // Lowering the duration below the current count ends the move at once.
        write_duration(DUR_W'(2));
        queue_request(ACT_TICK, 0, 0);
        queue_request(ACT_TICK, 0, 0);
        wait_drained();

        write_duration(16'hFFFF);
        queue_request(ACT_START, 5, -7);
        queue_request(ACT_TICK, 0, 0);
        queue_request(ACT_TICK, 0, 0);
        queue_request(ACT_START, 262143, 200000);
        queue_request(ACT_TICK, 0, 0);
        wait_drained();

        for (phase = 0; phase < 12; phase++) begin
            if (phase == 4) begin
                send_idle_pct = 59;
                recv_idle_pct = 12;
            end else if (phase == 8) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                0:       dur = 1;
                4:       dur = 65535;
                8:       dur = 2;
                11:      dur = $urandom_range(100, 300);
                default: dur = $urandom_range(3, 40);
            endcase
            write_duration(DUR_W'(dur));
            queue_moves(90);
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests and checked %0d profile points across %0d durations.",
                 requests_sent, points_checked, settings_used);
        $display("Idling ran sender-light, receiver-light and with no idling; %0d mismatches.",
                 mismatch_count);
        if (mismatch_count == 0 && expected_points.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ quintic_min_jerk_trajectory_core.f @@
rtl/qmj_pkg.sv
rtl/qmj_div.sv
rtl/qmj_dp.sv
rtl/qmj_ctrl.sv
rtl/quintic_min_jerk_trajectory_core.sv
test/testbench.sv
